[hdl/assert_macros.svh]
// Assertion macros used by the RTL.
// In synthesis builds the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// A condition that forces a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication failed");

// A condition that forces a consequence in the following cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[hdl/vncm_pkg.sv]
package vncm_pkg;

    // Field widths of the channels.
    localparam int BYTE_W      = 8;
    localparam int CODE_W      = 32;
    localparam int TFB_W       = 5;
    localparam int STATUS_W    = 2;
    localparam int RES_POS_W   = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_VOP_CODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_BITS  = 2'd2;

    // Register reset values.
    localparam logic [CODE_W-1:0] VOP_CODE_RST   = 32'h0000_01B6;
    localparam logic [CODE_W-1:0] GROUP_CODE_RST = 32'h0000_01B3;
    localparam logic [TFB_W-1:0]  TIME_BITS_RST  = 5'd16;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_SEARCH = 3'd1,
        PH_TYPE   = 3'd2,
        PH_RUN    = 3'd3,
        PH_MARK1  = 3'd4,
        PH_TIME   = 3'd5,
        PH_CODED  = 3'd6,
        PH_TAIL   = 3'd7
    } phase_t;

    // Frame status reported with the last word.
    typedef enum logic [STATUS_W-1:0] {
        ST_MARKED = 2'd0,
        ST_GROUP  = 2'd1,
        ST_BAD    = 2'd2
    } status_t;

    // Header parser state carried from one bit to the next.
    typedef struct packed {
        phase_t           phase;
        logic [TFB_W-1:0] count;
        logic             bad;
        logic             hit;
    } hdr_state_t;

endpackage

[hdl/vncm_if.sv]
// Frame byte channel.
interface vncm_in_if import vncm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// Result channel.
interface vncm_out_if import vncm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [BYTE_W-1:0]    out_byte;
    logic                 done_res;
    logic [STATUS_W-1:0]  status;
    logic [RES_POS_W-1:0] result_pos;

    modport source (output valid, output out_byte, output done_res, output status,
                    output result_pos, input ready);
    modport sink   (input valid, input out_byte, input done_res, input status,
                    input result_pos, output ready);
endinterface

// Configuration write channel.
interface vncm_cfg_if import vncm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

[hdl/vop_not_coded_marker_unit.sv]
// Words pass from the input stage register to the result register, one word
// per cycle unless the output stalls; the header bit walk is combinational.
// Reset (rst_n low, asynchronous) empties both stages, loads the start codes
// and time width with their defaults, and puts the parser at the start code.
// The parser also returns to that point after every last byte of a frame.
`include "assert_macros.svh"

module vop_not_coded_marker_unit import vncm_pkg::*; #(
    parameter int POS_BITS = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    vncm_in_if.sink    byte_ch,
    vncm_out_if.source result_ch,
    vncm_cfg_if.sink   cfg
);

    localparam int PW = (POS_BITS > RES_POS_W) ? POS_BITS : RES_POS_W;

    // Configuration registers.
    logic [CODE_W-1:0] vop_code_reg;
    logic [CODE_W-1:0] group_code_reg;
    logic [TFB_W-1:0]  time_bits_reg;

    // Input stage.
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_last_reg;
    logic              s1_adv;

    // Parser state.
    logic [POS_BITS-1:0]  byte_index_reg, byte_index_next;
    logic [CODE_W-1:0]    code_window_reg, code_window_next;
    phase_t               phase_reg, phase_next;
    logic [TFB_W-1:0]     field_count_reg, field_count_next;
    logic [RES_POS_W-1:0] found_pos_reg, found_pos_next;
    status_t              verdict_reg, verdict_next;

    // Result stage.
    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic                 out_done_reg;
    status_t              out_status_reg, out_status_next;
    logic [RES_POS_W-1:0] out_pos_reg, out_pos_next;

    // One header bit, most significant first.
    function automatic hdr_state_t hdr_bit(hdr_state_t s, logic b_v, logic [TFB_W-1:0] tfb);
        hdr_state_t r;
        r     = s;
        r.hit = 1'b0;
        case (s.phase)
            PH_TYPE:
            begin
                r.count = s.count + 1'b1;
                if (r.count >= TFB_W'(2))
                    r.phase = PH_RUN;
            end
            PH_RUN:
            begin
                if (!b_v)
                    r.phase = PH_MARK1;
            end
            PH_MARK1:
            begin
                if (!b_v)
                begin
                    r.phase = PH_TAIL;
                    r.bad   = 1'b1;
                end
                else
                begin
                    r.phase = PH_TIME;
                    r.count = '0;
                end
            end
            PH_TIME:
            begin
                if (s.count < tfb)
                    r.count = s.count + 1'b1;
                else if (!b_v)
                begin
                    r.phase = PH_TAIL;
                    r.bad   = 1'b1;
                end
                else
                    r.phase = PH_CODED;
            end
            PH_CODED:
            begin
                r.phase = PH_TAIL;
                r.hit   = 1'b1;
            end
            default:
            begin
                r = s;
                r.hit = 1'b0;
            end
        endcase
        return r;
    endfunction

    // Handshake: the input stage moves on when the result register is free.
    assign s1_adv          = s1_valid_reg && (!out_valid_reg || result_ch.ready);
    assign byte_ch.ready   = !s1_valid_reg || s1_adv;
    assign cfg.ready       = 1'b1;

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.out_byte   = out_byte_reg;
    assign result_ch.done_res   = out_done_reg;
    assign result_ch.status     = out_status_reg;
    assign result_ch.result_pos = out_pos_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vop_code_reg   <= VOP_CODE_RST;
            group_code_reg <= GROUP_CODE_RST;
            time_bits_reg  <= TIME_BITS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_VOP_CODE:   vop_code_reg   <= cfg.wdata;
                CFG_GROUP_CODE: group_code_reg <= cfg.wdata;
                CFG_TIME_BITS:  time_bits_reg  <= cfg.wdata[TFB_W-1:0];
                default:        ;
            endcase
        end
    end

    // Input stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (byte_ch.ready)
            s1_valid_reg <= byte_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.ready && byte_ch.valid)
        begin
            s1_byte_reg <= byte_ch.data_byte;
            s1_last_reg <= byte_ch.last;
        end
    end

    // Parser step for the word in the input stage.
    always_comb
    begin
        logic [CODE_W-1:0]    win;
        logic [PW-1:0]        idx_ext;
        logic [BYTE_W-1:0]    clr_mask;
        hdr_state_t           hs;

        win     = {code_window_reg[CODE_W-BYTE_W-1:0], s1_byte_reg};
        idx_ext = PW'(byte_index_reg);
        clr_mask = '1;

        code_window_next = code_window_reg;
        phase_next       = phase_reg;
        field_count_next = field_count_reg;
        found_pos_next   = found_pos_reg;
        verdict_next     = verdict_reg;
        byte_index_next  = byte_index_reg + 1'b1;
        out_status_next  = ST_MARKED;
        out_pos_next     = '0;

        hs.phase = phase_reg;
        hs.count = field_count_reg;
        hs.bad   = 1'b0;
        hs.hit   = 1'b0;

        case (phase_reg)
            PH_START:
            begin
                code_window_next = win;
                if (byte_index_reg == POS_BITS'(3))
                begin
                    if (win == group_code_reg)
                        phase_next = PH_SEARCH;
                    else if (win == vop_code_reg)
                    begin
                        phase_next       = PH_TYPE;
                        field_count_next = '0;
                    end
                    else
                    begin
                        phase_next   = PH_TAIL;
                        verdict_next = ST_BAD;
                    end
                end
            end
            PH_SEARCH:
            begin
                code_window_next = win;
                if (byte_index_reg >= POS_BITS'(7) && !s1_last_reg && win == vop_code_reg)
                begin
                    phase_next       = PH_TYPE;
                    field_count_next = '0;
                end
            end
            default:
            begin
                // Walk the eight header bits of this byte.
                for (int i = BYTE_W - 1; i >= 0; i--)
                begin
                    hs = hdr_bit(hs, s1_byte_reg[i], time_bits_reg);
                    if (hs.hit)
                    begin
                        clr_mask[i]    = 1'b0;
                        verdict_next   = ST_MARKED;
                        found_pos_next = RES_POS_W'(idx_ext);
                    end
                end
                if (hs.bad)
                    verdict_next = ST_BAD;
                phase_next       = hs.phase;
                field_count_next = hs.count;
            end
        endcase

        out_byte_next = s1_byte_reg & clr_mask;

        // Frame end: report and return to the start code.
        if (s1_last_reg)
        begin
            if (phase_next == PH_SEARCH)
            begin
                out_status_next = ST_GROUP;
                out_pos_next    = (byte_index_reg >= POS_BITS'(7))
                                ? RES_POS_W'(idx_ext - PW'(3)) : RES_POS_W'(4);
            end
            else if (phase_next == PH_TAIL && verdict_next == ST_MARKED)
            begin
                out_status_next = ST_MARKED;
                out_pos_next    = found_pos_next;
            end
            else
            begin
                out_status_next = ST_BAD;
                out_pos_next    = '0;
            end
            byte_index_next  = '0;
            code_window_next = '0;
            phase_next       = PH_START;
            field_count_next = '0;
            found_pos_next   = '0;
            verdict_next     = ST_BAD;
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg  <= '0;
            code_window_reg <= '0;
            phase_reg       <= PH_START;
            field_count_reg <= '0;
            found_pos_reg   <= '0;
            verdict_reg     <= ST_BAD;
        end
        else if (s1_adv)
        begin
            byte_index_reg  <= byte_index_next;
            code_window_reg <= code_window_next;
            phase_reg       <= phase_next;
            field_count_reg <= field_count_next;
            found_pos_reg   <= found_pos_next;
            verdict_reg     <= verdict_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || result_ch.ready)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_byte_reg   <= out_byte_next;
            out_done_reg   <= s1_last_reg;
            out_status_reg <= out_status_next;
            out_pos_reg    <= out_pos_next;
        end
    end

    // Checks on the pipeline and the parser.
    `ASSERT_IMPLIES(a_mid_frame_quiet, clk, rst_n, out_valid_reg && !out_done_reg, out_status_reg == ST_MARKED && out_pos_reg == '0)
    `ASSERT_NEXT(a_frame_restart, clk, rst_n, s1_adv && s1_last_reg, phase_reg == PH_START && byte_index_reg == '0)
    `ASSERT_IMPLIES(a_stall_full, clk, rst_n, !byte_ch.ready, s1_valid_reg && out_valid_reg)

endmodule

[test/tb_vop_not_coded_marker_unit.sv]
`timescale 1ns / 1ps

module tb_vop_not_coded_marker_unit;
    import vncm_pkg::*;

    localparam int ITEM_TARGET = 1850;
    localparam int PHASE_COUNT = 7;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PRINT_LIMIT = 20;

    // Kinds of frames the stimulus generator can build.
    typedef enum int {
        FR_PLANE,
        FR_GROUP_PLANE,
        FR_GROUP_ONLY,
        FR_SHORT,
        FR_BAD_MARK1,
        FR_BAD_MARK2,
        FR_BAD_CODE,
        FR_TINY,
        FR_NOISE
    } frame_kind_t;

    // Predicts the output word for every accepted frame byte and checks the results.
    class marker_scoreboard;
        typedef struct {
            logic [BYTE_W-1:0]    obyte;
            logic                 done;
            logic [STATUS_W-1:0]  st;
            logic [RES_POS_W-1:0] pos;
        } word_t;

        logic [CODE_W-1:0]    vop_code;
        logic [CODE_W-1:0]    grp_code;
        logic [TFB_W-1:0]     time_bits;

        logic [RES_POS_W-1:0] byte_index;
        logic [CODE_W-1:0]    window;
        phase_t               phase;
        logic [TFB_W-1:0]     cnt;
        logic [RES_POS_W-1:0] found_pos;
        status_t              verdict;

        word_t exp_q[$];
        int    errors;
        int    frames;
        int    status_seen[3];

        function new();
            vop_code  = VOP_CODE_RST;
            grp_code  = GROUP_CODE_RST;
            time_bits = TIME_BITS_RST;
            errors    = 0;
            frames    = 0;
            status_seen = '{0, 0, 0};
            clear_frame();
        endfunction

        function void clear_frame();
            byte_index = '0;
            window     = '0;
            phase      = PH_START;
            cnt        = '0;
            found_pos  = '0;
            verdict    = ST_BAD;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_VOP_CODE)
                vop_code = data;
            else if (idx == CFG_GROUP_CODE)
                grp_code = data;
            else if (idx == CFG_TIME_BITS)
                time_bits = data[TFB_W-1:0];
        endfunction

        function int pending();
            return exp_q.size();
        endfunction

        // Walk one byte through the header parser and queue the expected word.
        function void note_byte(logic [BYTE_W-1:0] b, logic lst);
            word_t                w;
            logic [RES_POS_W-1:0] idx;
            logic [RES_POS_W:0]   n;
            w.obyte = b;
            w.done  = lst;
            w.st    = ST_MARKED;
            w.pos   = '0;
            idx     = byte_index;
            if (phase == PH_START) begin
                window = {window[CODE_W-9:0], b};
                if (idx == 3) begin
                    if (window == grp_code) begin
                        phase = PH_SEARCH;
                    end
                    else if (window == vop_code) begin
                        phase = PH_TYPE;
                        cnt   = '0;
                    end
                    else begin
                        phase   = PH_TAIL;
                        verdict = ST_BAD;
                    end
                end
            end
            else if (phase == PH_SEARCH) begin
                window = {window[CODE_W-9:0], b};
                if (idx >= 7 && !lst && window == vop_code) begin
                    phase = PH_TYPE;
                    cnt   = '0;
                end
            end
            else begin
                for (int i = 7; i >= 0; i--) begin
                    case (phase)
                        PH_TYPE:
                        begin
                            cnt++;
                            if (cnt >= 2)
                                phase = PH_RUN;
                        end
                        PH_RUN:
                        begin
                            if (!b[i])
                                phase = PH_MARK1;
                        end
                        PH_MARK1:
                        begin
                            if (!b[i]) begin
                                phase   = PH_TAIL;
                                verdict = ST_BAD;
                            end
                            else begin
                                phase = PH_TIME;
                                cnt   = '0;
                            end
                        end
                        PH_TIME:
                        begin
                            if (cnt < time_bits) begin
                                cnt++;
                            end
                            else if (!b[i]) begin
                                phase   = PH_TAIL;
                                verdict = ST_BAD;
                            end
                            else begin
                                phase = PH_CODED;
                            end
                        end
                        PH_CODED:
                        begin
                            w.obyte[i] = 1'b0;
                            verdict    = ST_MARKED;
                            found_pos  = idx;
                            phase      = PH_TAIL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            byte_index = idx + 1'b1;

            // The status and position only mean something on the last byte.
            if (lst) begin
                if (phase == PH_SEARCH) begin
                    n     = {1'b0, idx} + 1'b1;
                    w.st  = ST_GROUP;
                    w.pos = (n >= 8) ? RES_POS_W'(n - 4) : RES_POS_W'(4);
                end
                else if (phase == PH_TAIL && verdict == ST_MARKED) begin
                    w.st  = ST_MARKED;
                    w.pos = found_pos;
                end
                else begin
                    w.st  = ST_BAD;
                    w.pos = '0;
                end
                clear_frame();
            end
            exp_q.push_back(w);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        // Compare one accepted result word with the oldest prediction.
        task check(logic [BYTE_W-1:0] ob, logic dn, logic [STATUS_W-1:0] st,
                   logic [RES_POS_W-1:0] pos);
            word_t w;
            if (exp_q.size() == 0) begin
                report($sformatf("unexpected word byte=%02h done=%0b status=%0d pos=%0d",
                                 ob, dn, st, pos));
            end
            else begin
                w = exp_q.pop_front();
                if (ob !== w.obyte || dn !== w.done || st !== w.st || pos !== w.pos)
                    report($sformatf("got byte=%02h done=%0b status=%0d pos=%0d, %s%02h %0b %0d %0d",
                                     ob, dn, st, pos, "wanted ", w.obyte, w.done, w.st,
                                     w.pos));
                if (w.done) begin
                    frames++;
                    status_seen[w.st]++;
                end
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    vncm_in_if  byte_if ();
    vncm_out_if res_if ();
    vncm_cfg_if cfg_if ();

    vop_not_coded_marker_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_if),
        .result_ch (res_if),
        .cfg       (cfg_if)
    );

    marker_scoreboard  sb;
    logic [BYTE_W-1:0] frame_q[$];
    int                bytes_sent;
    int                cycles;
    int                stall_pct;
    int                stall_left;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap lengths: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Result side stalls; a zero stall rate gives stretches with ready held high.
    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            stall_left--;
            res_if.ready <= 1'b0;
        end
        else begin
            res_if.ready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct)
                stall_left = pick_gap() + 1;
        end
    end

    // Every accepted result word goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            sb.check(res_if.out_byte, res_if.done_res, res_if.status, res_if.result_pos);
    end

    // Run time limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words outstanding", cycles, sb.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void put_word(logic [CODE_W-1:0] v);
        for (int k = 3; k >= 0; k--)
            frame_q.push_back(v[8*k +: 8]);
    endfunction

    function automatic void put_junk(int count);
        repeat (count)
            frame_q.push_back(BYTE_W'($urandom_range(0, 255)));
    endfunction

    // Length of the run of ones in the header: usually short.
    function automatic int pick_run();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(0, 3);
        else if (r < 9)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    // Build one frame into frame_q; a negative run length picks one at random.
    function automatic void build_frame(frame_kind_t kind, int run_len);
        bit                hb[$];
        logic [BYTE_W-1:0] v;
        int                run;
        int                cut;
        frame_q.delete();
        case (kind)
            FR_PLANE, FR_SHORT, FR_BAD_MARK1, FR_BAD_MARK2:
                put_word(sb.vop_code);
            FR_GROUP_PLANE:
            begin
                put_word(sb.grp_code);
                put_junk($urandom_range(0, 6));
                put_word(sb.vop_code);
            end
            FR_GROUP_ONLY:
            begin
                put_word(sb.grp_code);
                put_junk($urandom_range(0, 12));
            end
            FR_BAD_CODE:
            begin
                put_word($urandom());
                put_junk($urandom_range(0, 8));
            end
            FR_TINY:
                put_junk($urandom_range(1, 3));
            default:
                put_junk($urandom_range(4, 20));
        endcase

        // Header bits, MSB first, then padding and some trailing bytes.
        if (kind inside {FR_PLANE, FR_SHORT, FR_BAD_MARK1, FR_BAD_MARK2, FR_GROUP_PLANE}) begin
            run = (run_len >= 0) ? run_len : pick_run();
            repeat (2)
                hb.push_back($urandom_range(0, 1));
            repeat (run)
                hb.push_back(1'b1);
            hb.push_back(1'b0);
            hb.push_back(kind != FR_BAD_MARK1);
            repeat (sb.time_bits)
                hb.push_back($urandom_range(0, 1));
            hb.push_back(kind != FR_BAD_MARK2);
            hb.push_back($urandom_range(0, 1));
            while (hb.size() % 8 != 0)
                hb.push_back($urandom_range(0, 1));
            while (hb.size() != 0) begin
                for (int k = 7; k >= 0; k--)
                    v[k] = hb.pop_front();
                frame_q.push_back(v);
            end
            put_junk($urandom_range(0, 3));
        end

        // A frame cut off somewhere before its end.
        if (kind == FR_SHORT) begin
            cut = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > cut)
                void'(frame_q.pop_back());
        end
    endfunction

    // Send frame_q, one word per handshake; valid stays high between back to back words.
    task automatic send_frame(bit no_idle);
        int  gap;
        logic lst;
        for (int k = 0; k < frame_q.size(); k++) begin
            gap = no_idle ? 0 : pick_gap();
            lst = (k == frame_q.size() - 1);
            if (gap > 0) begin
                byte_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            byte_if.valid     <= 1'b1;
            byte_if.data_byte <= frame_q[k];
            byte_if.last      <= lst;
            do
                @(posedge clk);
            while (!byte_if.ready);
            sb.note_byte(frame_q[k], lst);
            bytes_sent++;
        end
    endtask

    // Hold off the sender until every predicted word has come back.
    task automatic drain();
        byte_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all three registers back to back, then release the channel.
    task automatic write_regs(logic [CODE_W-1:0] vop, logic [CODE_W-1:0] grp,
                              logic [CFG_DATA_W-1:0] tfb_word);
        logic [CFG_IDX_W-1:0]  idx[3];
        logic [CFG_DATA_W-1:0] val[3];
        idx = '{CFG_VOP_CODE, CFG_GROUP_CODE, CFG_TIME_BITS};
        val = '{vop, grp, tfb_word};
        for (int k = 0; k < 3; k++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx[k];
            cfg_if.wdata <= val[k];
            do
                @(posedge clk);
            while (!cfg_if.ready);
            sb.set_reg(idx[k], val[k]);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Main stimulus.
    initial
    begin
        frame_kind_t           kind;
        int                    r;
        logic [CODE_W-1:0]     code_a;
        logic [CFG_DATA_W-1:0] tfb_word;

        sb         = new();
        bytes_sent = 0;
        cycles     = 0;
        stall_pct  = 0;
        stall_left = 0;

        rst_n             = 1'b0;
        byte_if.valid     = 1'b0;
        byte_if.data_byte = '0;
        byte_if.last      = 1'b0;
        res_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = CFG_VOP_CODE;
        cfg_if.wdata      = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames with the reset register values.
        // Coded flag on the first bit of a new byte, then on the last bit of one.
        build_frame(FR_PLANE, 3);
        send_frame(1'b1);
        build_frame(FR_PLANE, 2);
        send_frame(1'b0);
        // Group code alone: a group frame shorter than eight bytes.
        frame_q.delete();
        put_word(sb.grp_code);
        send_frame(1'b1);
        // A single all-ones byte, and an all-zero start code.
        frame_q = '{8'hFF};
        send_frame(1'b0);
        frame_q = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_frame(1'b1);
        // A zero first marker.
        build_frame(FR_BAD_MARK1, 0);
        send_frame(1'b0);

        // Random frames, one register setting per phase.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            if (ph > 0) begin
                drain();
                code_a = $urandom();
                case (ph)
                    1: write_regs($urandom(), $urandom(), 32'd1);
                    2: write_regs(32'h0000_0000, 32'hFFFF_FFFF, 32'd0);
                    // Equal codes; the time width word carries junk above its field.
                    3:
                    begin
                        tfb_word = $urandom();
                        tfb_word[TFB_W-1:0] = 5'd31;
                        write_regs(code_a, code_a, tfb_word);
                    end
                    4: write_regs(32'hFFFF_FFFF, 32'h0000_0000, 32'd17);
                    5: write_regs($urandom(), $urandom(), $urandom_range(1, 16));
                    default: write_regs(VOP_CODE_RST, GROUP_CODE_RST, TIME_BITS_RST);
                endcase
            end
            while (bytes_sent < (ph + 1) * ITEM_TARGET / PHASE_COUNT) begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    kind = FR_PLANE;
                else if (r < 60)
                    kind = FR_GROUP_PLANE;
                else if (r < 70)
                    kind = FR_GROUP_ONLY;
                else if (r < 80)
                    kind = FR_SHORT;
                else if (r < 85)
                    kind = FR_BAD_MARK1;
                else if (r < 90)
                    kind = FR_BAD_MARK2;
                else if (r < 95)
                    kind = FR_BAD_CODE;
                else if (r < 98)
                    kind = FR_TINY;
                else
                    kind = FR_NOISE;
                r = $urandom_range(0, 9);
                stall_pct = (r < 3) ? 0 : ((r < 7) ? 20 : 50);
                build_frame(kind, -1);
                send_frame($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 99) < 3)
                    drain();
            end
        end

        drain();
        repeat (10) @(posedge clk);

        $display("Sent %0d bytes in %0d frames over %0d register settings.",
                 bytes_sent, sb.frames, PHASE_COUNT);
        $display("Frames ending marked: %0d, group without plane: %0d, bad header: %0d.",
                 sb.status_seen[ST_MARKED], sb.status_seen[ST_GROUP],
                 sb.status_seen[ST_BAD]);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/vncm_pkg.sv
hdl/vncm_if.sv
hdl/vop_not_coded_marker_unit.sv
test/tb_vop_not_coded_marker_unit.sv
